@@ src/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ src/hkvt_pkg.sv @@
// types and constants of the hashed key-value table
package hkvt_pkg;
  localparam int BUCKETS    = 64;
  localparam int WAYS       = 4;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SLOTS      = BUCKETS * WAYS;
  localparam int CNT_W      = $clog2(SLOTS + 1);

  localparam logic [1:0] FUNC_SET    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]            func;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [BKT_W-1:0]      bucket;
  } op_t;
endpackage

@@ src/hkvt_front.sv @@
// front end: takes items, reduces the key and works out the bucket
module hkvt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [31:0]                   key,
  input  logic [31:0]                   value_in,
  output logic                          q_valid,
  input  logic                          q_ready,
  output hkvt_pkg::op_t                 q_op
);
  import hkvt_pkg::*;
  `include "assert_macros.svh"

  // two-entry queue towards the back end
  op_t        mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  op_t        op_in;
  logic [63:0] key_ext, val_ext;
  logic       push, pop;

  always_comb begin
    key_ext = {32'd0, key};
    val_ext = {32'd0, value_in};
    op_in.func   = func;
    op_in.key    = key_ext[KEY_BITS-1:0];
    op_in.value  = val_ext[VALUE_BITS-1:0];
    op_in.bucket = BKT_W'(op_in.key % BUCKETS);
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_op     = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= op_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_NEVER(a_fill_range, clk, rst, fill == 2'd3)
  `ASSERT_IMPL(a_full_ptrs, clk, rst, (fill == 2'd2) |-> (wr_ptr == rd_ptr))
  `ASSERT_IMPL(a_empty_ptrs, clk, rst, (fill == 2'd0) |-> (wr_ptr == rd_ptr))
endmodule

@@ src/hkvt_back.sv @@
// back end: bucket row read, way compare, write back and result register
module hkvt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  hkvt_pkg::op_t                 q_op,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [31:0]                   value_out,
  output logic                          status,
  output logic [8:0]                    entry_count
);
  import hkvt_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  op_t    op;
  logic [BKT_W-1:0] clr_idx;
  logic [WAYS-1:0] vmem [BUCKETS];
  logic [KEY_BITS-1:0]   kmem [BUCKETS][WAYS];
  logic [VALUE_BITS-1:0] dmem [BUCKETS][WAYS];
  logic [WAYS-1:0]       row_v;
  logic [KEY_BITS-1:0]   row_k [WAYS];
  logic [VALUE_BITS-1:0] row_d [WAYS];
  logic [CNT_W-1:0] count;

  logic [WAYS-1:0] match_v, free_v, wr_way;
  logic            any_match, any_free;
  logic [VALUE_BITS-1:0] match_val;
  logic [WAYS-1:0] row_v_next;
  logic            do_ins, do_rem, do_upd;
  logic [63:0]     vo_ext;

  assign q_ready = (state == ST_IDLE) && !(out_valid && !out_ready);

  always_comb begin
    match_v = '0; free_v = '0; match_val = '0;
    any_match = 1'b0; any_free = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (row_v[w] && row_k[w] == op.key && !any_match) begin
        match_v[w] = 1'b1; any_match = 1'b1; match_val = row_d[w];
      end
      if (!row_v[w] && !any_free) begin
        free_v[w] = 1'b1; any_free = 1'b1;
      end
    end
    do_upd = (op.func == FUNC_SET) && any_match;
    do_ins = (op.func == FUNC_SET) && !any_match && any_free;
    do_rem = (op.func == FUNC_REMOVE) && any_match;
    wr_way = do_upd ? match_v : free_v;
    row_v_next = row_v;
    if (do_ins) row_v_next = row_v | free_v;
    if (do_rem) row_v_next = row_v & ~match_v;
    vo_ext = '0;
    if (op.func == FUNC_LOOKUP && any_match) vo_ext[VALUE_BITS-1:0] = match_val;
  end

  // bucket row memories, registered reads
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) vmem[clr_idx] <= '0;
    else if (state == ST_EXEC && (do_ins || do_rem)) vmem[op.bucket] <= row_v_next;
    if (q_valid && q_ready) row_v <= vmem[q_op.bucket];
  end

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    always_ff @(posedge clk) begin
      if (state == ST_EXEC && (do_ins || do_upd) && wr_way[w]) begin
        kmem[op.bucket][w] <= op.key;
        dmem[op.bucket][w] <= op.value;
      end
      if (q_valid && q_ready) begin
        row_k[w] <= kmem[q_op.bucket][w];
        row_d[w] <= dmem[q_op.bucket][w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) op <= q_op;
    if (state == ST_EXEC) begin
      hit       <= any_match;
      value_out <= vo_ext[31:0];
      status    <= (op.func == FUNC_SET) && !any_match && !any_free;
      entry_count <= 9'(count + (do_ins ? CNT_W'(1) : '0) - (do_rem ? CNT_W'(1) : '0));
    end
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == BUCKETS - 1) state <= ST_IDLE;
        end
        ST_IDLE: if (q_valid && q_ready) state <= ST_EXEC;
        ST_EXEC: begin
          out_valid <= 1'b1;
          if (do_ins) count <= count + 1'b1;
          else if (do_rem) count <= count - 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_overrun, clk, rst, (state == ST_EXEC) |-> !(out_valid && !out_ready))
  `ASSERT_NEVER(a_one_write, clk, rst, (state == ST_EXEC) && do_ins && do_rem)
  `ASSERT_IMPL(a_cnt_bound, clk, rst, (state == ST_EXEC && do_ins) |-> (32'(count) < SLOTS))
endmodule

@@ src/hashed_key_value_table.sv @@
// top level of the hashed key-value table
// A key-value map of 64 buckets of 4 ways, bucket chosen as key modulo 64.
// func 0 sets (updates a present key or inserts into the lowest free way;
// a full bucket refuses and sets status), 1 removes, 2 looks up. Every item
// gives one result with hit, value_out (lookup hits only), status and the
// entry count after the operation. Items enter a two-entry queue; the back
// end takes one item at a time: it reads the bucket row as it takes the
// item, then compares all ways and writes back, and only then takes the
// next item. While a result waits to be taken, the back end takes no new
// item, so the stall lasts as long as the receiver holds off. After reset
// the way valid bits are cleared one bucket a cycle, during which queued
// items wait.
module hashed_key_value_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] key,
  input  logic [31:0] value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] value_out,
  output logic        status,
  output logic [8:0]  entry_count
);
  import hkvt_pkg::*;

  // queue between front and back
  logic q_valid, q_ready;
  op_t  q_op;

  hkvt_front u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .key, .value_in,
    .q_valid, .q_ready, .q_op
  );

  hkvt_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_op,
    .out_valid, .out_ready, .hit, .value_out, .status, .entry_count
  );
endmodule

@@ sim/testbench.sv @@
// self-checking testbench of the hashed key-value table
`timescale 1ns / 1ps

module testbench;
  import hkvt_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
  } table_op_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic        status;
    logic [8:0]  count;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [31:0] key = '0;
  logic [31:0] value_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [31:0] value_out;
  logic        status;
  logic [8:0]  entry_count;
  logic        in_taken = 1'b0;

  hashed_key_value_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .key(key), .value_in(value_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .value_out(value_out), .status(status), .entry_count(entry_count)
  );

  always #10 clk = ~clk;

  // shadow copy of the table contents
  logic        shadow_valid [SLOTS];
  logic [31:0] shadow_key   [SLOTS];
  logic [31:0] shadow_value [SLOTS];
  int unsigned shadow_entries = 0;

  table_op_t    pending_ops [$];
  table_reply_t expected_replies [$];
  int  mismatches = 0;
  int  send_idle_pct = 30;
  int  recv_idle_pct = 81;
  int  hold_off_cycles = 0;
  bit  stimulus_done = 1'b0;

  // predict one reply and update the shadow table
  function automatic table_reply_t apply_op(table_op_t op);
    table_reply_t r;
    int base, match, free_way;
    base = (op.key % BUCKETS) * WAYS;
    match = -1;
    free_way = -1;
    r = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        if (match < 0 && shadow_key[base + w] == op.key) match = base + w;
      end else if (free_way < 0) begin
        free_way = base + w;
      end
    end
    r.hit = (match >= 0);
    case (op.func)
      FUNC_SET: begin
        if (match >= 0) begin
          shadow_value[match] = op.value;
        end else if (free_way >= 0) begin
          shadow_valid[free_way] = 1'b1;
          shadow_key[free_way] = op.key;
          shadow_value[free_way] = op.value;
          shadow_entries++;
        end else begin
          r.status = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (match >= 0) begin
          shadow_valid[match] = 1'b0;
          shadow_entries--;
        end
      end
      FUNC_LOOKUP: begin
        if (match >= 0) r.value = shadow_value[match];
      end
      default: ;
    endcase
    r.count = shadow_entries[8:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void push_op(logic [1:0] f, logic [31:0] k, logic [31:0] v);
    table_op_t op;
    op.func = f;
    op.key = k;
    op.value = v;
    pending_ops.push_back(op);
  endfunction

  // input accepts seen at the rising edge; prediction is made here
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      expected_replies.push_back(apply_op({func, key, value_in}));
    end
  end

  // driver: offers the next item once the current one has been taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          table_op_t op;
          op = pending_ops.pop_front();
          in_valid <= 1'b1;
          func <= op.func;
          key <= op.key;
          value_in <= op.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with a long hold-off when the test sets one
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor: compare each reply with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("unexpected reply at %0t", $realtime);
        mismatches++;
      end else begin
        table_reply_t want;
        want = expected_replies.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (value_out !== want.value) report_mismatch("value_out", value_out, want.value);
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (entry_count !== want.count)
          report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (!stimulus_done) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // random item; keys mostly from a small pool so that buckets fill
  function automatic void push_random_op();
    logic [31:0] k;
    logic [1:0]  f;
    int sel;
    sel = $urandom_range(99);
    if (sel < 85) k = ($urandom_range(7) * BUCKETS) + $urandom_range(5);
    else k = $urandom();
    sel = $urandom_range(99);
    if (sel < 45) f = FUNC_SET;
    else if (sel < 70) f = FUNC_REMOVE;
    else if (sel < 97) f = FUNC_LOOKUP;
    else f = FUNC_UNUSED;
    push_op(f, k, $urandom());
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int guard;
    for (int s = 0; s < SLOTS; s++) shadow_valid[s] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, full bucket refusal, miss cases, unused code
    push_op(FUNC_LOOKUP, 32'd0, 32'hFFFF_FFFF);
    push_op(FUNC_REMOVE, 32'd0, 32'd0);
    push_op(FUNC_SET, 32'd0, 32'hFFFF_FFFF);
    push_op(FUNC_SET, 32'hFFFF_FFC0, 32'd0);
    push_op(FUNC_SET, 32'd64, 32'h1234_5678);
    push_op(FUNC_SET, 32'd128, 32'h8765_4321);
    push_op(FUNC_SET, 32'd192, 32'hA5A5_A5A5);
    push_op(FUNC_LOOKUP, 32'd192, 32'd0);
    push_op(FUNC_SET, 32'd0, 32'h5A5A_5A5A);
    push_op(FUNC_LOOKUP, 32'd0, 32'd0);
    push_op(FUNC_LOOKUP, 32'hFFFF_FFC0, 32'd0);
    push_op(FUNC_UNUSED, 32'd64, 32'hFFFF_FFFF);
    push_op(FUNC_UNUSED, 32'd5, 32'd0);
    push_op(FUNC_REMOVE, 32'd64, 32'd0);
    push_op(FUNC_LOOKUP, 32'd64, 32'd0);
    push_op(FUNC_SET, 32'hFFFF_FFFF, 32'd1);
    push_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    push_op(FUNC_SET, 32'd256, 32'd7);
    push_op(FUNC_LOOKUP, 32'd320, 32'd0);
    drain();

    // phase one: sender sparse idling, receiver heavy
    for (int i = 0; i < 580; i++) push_random_op();
    drain();

    // receiver holds off long while items keep coming
    send_idle_pct = 81;
    recv_idle_pct = 30;
    hold_off_cycles = 200;
    for (int i = 0; i < 580; i++) push_random_op();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 580; i++) push_random_op();
    drain();

    stimulus_done = 1'b1;
    guard = 0;
    while (guard < 20) begin
      @(posedge clk);
      guard++;
    end
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // bound on the draining waits
  initial begin
    #(20ns * 1000000);
    $display("== FAIL ==");
    $finish;
  end
endmodule
